@@ rtl/core/ecd_pkg.sv @@
// Shared constants and codes for the elastic-net coordinate descent block.
// No dependencies; the other files of the block, except ecd_mul, refer to it by scoped names.
`timescale 1ns / 1ps

package ecd_pkg;

  // Parameter defaults for the top level
  localparam int MAX_SAMPLES_DEF  = 256;
  localparam int MAX_FEATURES_DEF = 16;
  localparam int VALUE_WIDTH_DEF  = 32;

  // Fixed widths of the channel fields
  localparam int ACTION_W  = 2;
  localparam int SIDX_W    = 8;
  localparam int FIDX_W    = 4;
  localparam int WORD_W    = 32;

  // Wide arithmetic widths
  localparam int WIDE_W    = 48;
  localparam int ACC_W     = 64;

  // Configuration port
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  typedef logic [ACTION_W-1:0] action_t;
  localparam action_t ACT_LOAD_X = 2'd0;
  localparam action_t ACT_LOAD_Y = 2'd1;
  localparam action_t ACT_FIT    = 2'd2;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_ALPHA    = 3'd0;
  localparam reg_idx_t REG_L1_SHARE = 3'd1;
  localparam reg_idx_t REG_ITER_LIM = 3'd2;
  localparam reg_idx_t REG_TOL      = 3'd3;
  localparam reg_idx_t REG_ICPT_EN  = 3'd4;
  localparam reg_idx_t REG_SAMPLES  = 3'd5;
  localparam reg_idx_t REG_FEATURES = 3'd6;

  localparam logic KIND_WEIGHT    = 1'b0;
  localparam logic KIND_INTERCEPT = 1'b1;

  // Register reset values
  localparam logic [30:0] ALPHA_RST    = 31'd65536;
  localparam logic [16:0] SHARE_RST    = 17'd32768;
  localparam logic [16:0] SHARE_ONE    = 17'd65536;
  localparam logic [15:0] ITER_LIM_RST = 16'd1000;
  localparam logic [30:0] TOL_RST      = 31'd7;
  localparam logic [8:0]  SAMPLES_RST  = 9'd256;
  localparam logic [4:0]  FEATURES_RST = 5'd16;

endpackage

@@ rtl/core/ecd_if.sv @@
// Valid/ready channel interfaces for input and result words.
// Depends on ecd_pkg for the field widths.
`timescale 1ns / 1ps

interface ecd_in_if;
  logic                            valid;
  logic                            ready;
  logic [ecd_pkg::ACTION_W-1:0]    action;
  logic [ecd_pkg::SIDX_W-1:0]      sample_index;
  logic [ecd_pkg::FIDX_W-1:0]      feature_index;
  logic signed [ecd_pkg::WORD_W-1:0] value;

  modport source (output valid, action, sample_index, feature_index, value, input ready);
  modport sink   (input valid, action, sample_index, feature_index, value, output ready);
endinterface

interface ecd_out_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [ecd_pkg::FIDX_W-1:0]      weight_index;
  logic signed [ecd_pkg::WORD_W-1:0] coefficient;
  logic                            converged;
  logic                            last;

  modport source (output valid, kind, weight_index, coefficient, converged, last, input ready);
  modport sink   (input valid, kind, weight_index, coefficient, converged, last, output ready);
endinterface

@@ rtl/core/ecd_mul.sv @@
// Shared unsigned multiplier with a registered product and sign flag.
// No dependencies beyond its width parameter.
`timescale 1ns / 1ps

module ecd_mul #(
  parameter int MW = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [MW-1:0]   a_i,
  input  logic [MW-1:0]   b_i,
  input  logic            neg_i,
  output logic [2*MW-1:0] prod_o,
  output logic            neg_o
);

  logic [2*MW-1:0] prod_q;
  logic            neg_q;

  // Register the magnitude product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (2*MW)'(a_i) * (2*MW)'(b_i);
      neg_q  <= neg_i;
    end
  end

  assign prod_o = prod_q;
  assign neg_o  = neg_q;

endmodule

@@ rtl/core/ecd_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on ecd_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps

module ecd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ecd_pkg::ACC_W-1:0]     dividend_i,
  input  logic [ecd_pkg::WIDE_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [ecd_pkg::ACC_W-1:0]     quotient_o
);

  localparam int DW = ecd_pkg::ACC_W;
  localparam int VW = ecd_pkg::WIDE_W;
  localparam int CW = $clog2(DW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dvd_q;
  logic [VW-1:0] rem_q, dvs_q;
  logic [VW:0]   trial;
  logic          ge;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_q, dvd_q[DW-1]};
    ge    = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits replace the dividend from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? VW'(trial - {1'b0, dvs_q}) : VW'(trial);
      dvd_q <= {dvd_q[DW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

@@ rtl/core/elastic_net_coordinate_descent_top.sv @@
// Elastic-net coordinate descent fitter: sample/target stores, sequencer, outputs.
// Depends on ecd_pkg, ecd_if, ecd_mul and ecd_div.
//
// Load words (feature or target values) give no result; the block takes them
// back to back while idle. A fit word runs a sequencer over one shared
// multiplier and one divider, and the block takes no input word until the
// results are queued. With n samples and f features the fit runs a setup pass,
// then sweeps (a feature whose divisor is not positive skips its divide and
// update), then the intercept (zero when the intercept is off), then f + 1
// result words that leave through an output register at up to one per cycle
// while the sink is ready. Cost is set by the memory read and the multiplier
// each sample element passes through, and by the divider once per feature in
// setup and in each sweep where the divisor is positive. The sample and target
// stores are not cleared after reset; reading an entry that was never loaded
// gives whatever it holds. Weights are cleared by each fit.
`timescale 1ns / 1ps

module elastic_net_coordinate_descent_top #(
  parameter int MAX_SAMPLES  = ecd_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_FEATURES = ecd_pkg::MAX_FEATURES_DEF,
  parameter int VALUE_WIDTH  = ecd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ecd_pkg::APB_AW-1:0]  paddr,
  input  logic [ecd_pkg::APB_DW-1:0]  pwdata,
  output logic [ecd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  ecd_in_if.sink                      in_i,
  ecd_out_if.source                   out_o
);

  localparam int MS  = MAX_SAMPLES;
  localparam int MF  = MAX_FEATURES;
  localparam int VW  = VALUE_WIDTH;
  localparam int SIW = (MS > 1) ? $clog2(MS) : 1;
  localparam int NW  = $clog2(MS + 1);
  localparam int FIW = (MF > 1) ? $clog2(MF) : 1;
  localparam int FW  = $clog2(MF + 1);
  localparam int AW  = $clog2(MS * MF);
  localparam int MW  = (VW > 32) ? VW : 32;
  localparam int PW  = 2 * MW;
  localparam int WW  = ecd_pkg::WIDE_W;
  localparam int CW  = ecd_pkg::ACC_W;

  localparam logic signed [65:0] VMAX66 = (66'sd1 <<< (VW - 1)) - 66'sd1;
  localparam logic signed [65:0] VMIN66 = -VMAX66 - 66'sd1;
  localparam logic signed [65:0] WMAX66 = (66'sd1 <<< (WW - 1)) - 66'sd1;
  localparam logic signed [65:0] I32MAX = (66'sd1 <<< 31) - 66'sd1;
  localparam logic signed [65:0] I32MIN = -I32MAX - 66'sd1;
  localparam logic [CW-1:0]      QMIN   = CW'(1) << (VW - 1);
  localparam logic [CW-1:0]      QMAX   = QMIN - CW'(1);
  localparam logic [PW-1:0]      SQ_MAX = PW'(64'hFFFF_FFFF_FFFF_FFFF);
  localparam logic [PW-1:0]      WMAXP  = PW'(WMAX66[WW-2:0]);

  typedef enum logic [5:0] {
    S_IDLE, S_P1, S_P2, S_P3, S_P4, S_P5,
    S_TS_RD, S_TS_ACC, S_TM_DIV, S_TM_WAIT, S_YC_RD, S_YC_WR,
    S_CM_RD, S_CM_ACC, S_CM_DIV, S_CM_WAIT, S_XC_RD, S_XC_WR, S_XC_ACC,
    S_IT_CHK, S_RH_RD, S_RH_M1, S_RH_M2, S_RH_ACC, S_W_CHK, S_W_WAIT,
    S_U_RD, S_U_M1, S_U_M2, S_U_WR, S_DS_MUL, S_DS_ACC, S_CONV,
    S_IC, S_IC_MUL, S_IC_ACC, S_EMIT
  } state_e;

  // Saturate to the value range
  function automatic logic signed [VW-1:0] sat_val(input logic signed [65:0] v);
    if (v > VMAX66) return VW'(VMAX66);
    if (v < VMIN66) return VW'(VMIN66);
    return VW'(v);
  endfunction

  // Saturate to the wide range
  function automatic logic signed [WW-1:0] sat_wide(input logic signed [65:0] v);
    if (v > WMAX66) return WW'(WMAX66);
    if (v < -WMAX66) return WW'(-WMAX66);
    return WW'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > I32MAX) return 32'(I32MAX);
    if (v < I32MIN) return 32'(I32MIN);
    return 32'(v);
  endfunction

  function automatic logic [VW-1:0] mag_v(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  // Q16 product from a raw magnitude product: shift, clamp, apply sign
  function automatic logic signed [WW-1:0] q16(input logic [PW-1:0] p, input logic neg);
    logic [PW-1:0] m;
    m = p >> 16;
    if (m > WMAXP) m = WMAXP;
    return neg ? -$signed(WW'(m)) : $signed(WW'(m));
  endfunction

  // Configuration registers
  logic [30:0] alpha_q, tol_q;
  logic [16:0] share_q;
  logic [15:0] limit_q;
  logic        icpt_en_q;
  logic [8:0]  samples_q;
  logic [4:0]  features_q;

  // Sequencer state
  state_e                 state_q;
  logic [NW-1:0]          i_q, n_q;
  logic [FW-1:0]          j_q, f_q;
  logic [15:0]            it_q;
  logic signed [CW-1:0]   acc_q;
  logic [31:0]            l1_q, l2_q;
  logic signed [WW-1:0]   thr_q, rho_q, tmp_q;
  logic [63:0]            tol2_q, dsum_q;
  logic signed [VW-1:0]   tm_q, wnew_q, icpt_q;
  logic                   num_neg_q, conv_q;
  logic signed [VW-1:0]   weights_q [MF];
  logic signed [VW-1:0]   prev_q    [MF];
  logic signed [VW-1:0]   mean_q    [MF];
  logic signed [WW-1:0]   css_q     [MF];

  // Result register
  logic                   ov_q, okind_q, oconv_q, olast_q;
  logic [3:0]             oidx_q;
  logic signed [31:0]     ocoef_q;

  // Memories and their read registers
  logic signed [VW-1:0]   smp_mem [MS*MF];
  logic signed [VW-1:0]   xc_mem  [MS*MF];
  logic signed [VW-1:0]   tgt_mem [MS];
  logic signed [VW-1:0]   yc_mem  [MS];
  logic signed [CW-1:0]   fs_mem  [MS];
  logic signed [VW-1:0]   smp_rd_q, xc_rd_q, tgt_rd_q, yc_rd_q;
  logic signed [CW-1:0]   fs_rd_q;

  // Shared units
  logic [MW-1:0]          mul_a, mul_b;
  logic                   mul_neg, mul_en;
  logic [PW-1:0]          prod;
  logic                   prod_neg;
  logic                   div_start, div_done;
  logic [CW-1:0]          div_dvd, div_q;
  logic [WW-1:0]          div_dvs;

  // Combinational datapath
  logic                   in_fire, out_fire, cfg_wr;
  logic [SIW-1:0]         i_idx;
  logic [FIW-1:0]         j_idx;
  logic [AW-1:0]          x_addr, ld_addr;
  logic                   last_i, last_j;
  logic signed [VW-1:0]   w_j, prev_j, mean_j, ld_val, c_val, r_val, yc_val;
  logic signed [WW-1:0]   css_j, q16_p, denom;
  logic signed [WW:0]     num;
  logic [CW-1:0]          num_mag, acc_mag;
  logic signed [CW-1:0]   acc_sum, fs_new;
  logic signed [VW-1:0]   mean_res, w_res;
  logic signed [VW:0]     dw;
  logic [VW-1:0]          dmag;
  logic [63:0]            sq;
  logic [64:0]            dsum_add;
  logic [16:0]            share_c;
  logic [NW-1:0]          n_c;
  logic [FW-1:0]          f_c;
  logic                   smp_we, tgt_we, smp_re, tgt_re, xc_we, xc_re, yc_we, fs_we, fs_re;
  logic                   yfs_re;
  logic signed [CW-1:0]   fs_wdata;

  assign in_fire  = in_i.valid && (state_q == S_IDLE);
  assign out_fire = ov_q && out_o.ready;
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    i_idx   = i_q[SIW-1:0];
    j_idx   = j_q[FIW-1:0];
    x_addr  = AW'(AW'(i_idx) * AW'(MF)) + AW'(j_idx);
    ld_addr = AW'(AW'(in_i.sample_index) * AW'(MF)) + AW'(in_i.feature_index);
    last_i  = NW'(i_q + 1'b1) == n_q;
    last_j  = FW'(j_q + 1'b1) == f_q;
    w_j     = weights_q[j_idx];
    prev_j  = prev_q[j_idx];
    mean_j  = mean_q[j_idx];
    css_j   = css_q[j_idx];
    q16_p   = q16(prod, prod_neg);
    ld_val  = sat_val(66'(in_i.value));
    c_val   = sat_val(66'(smp_rd_q) - 66'(mean_j));
    yc_val  = sat_val(66'(tgt_rd_q) - 66'(tm_q));
    r_val   = sat_val(66'(yc_rd_q) - (66'(fs_rd_q) - 66'(q16_p)));
    acc_sum = acc_q + CW'(q16_p);
    fs_new  = fs_rd_q + CW'(tmp_q) - CW'(q16_p);
    denom   = sat_wide(66'(css_j) + $signed({34'd0, l2_q}));
    if (rho_q > thr_q)       num = (WW+1)'(rho_q) - (WW+1)'(thr_q);
    else if (rho_q < -thr_q) num = (WW+1)'(rho_q) + (WW+1)'(thr_q);
    else                     num = '0;
    num_mag = num[WW] ? CW'(-num) : CW'(num);
    acc_mag = acc_q[CW-1] ? CW'(-acc_q) : CW'(acc_q);
    mean_res = acc_q[CW-1] ? VW'(-$signed(div_q)) : VW'(div_q);
    if (num_neg_q) w_res = (div_q > QMIN) ? VW'(VMIN66) : VW'(-$signed(div_q));
    else           w_res = (div_q > QMAX) ? VW'(VMAX66) : VW'(div_q);
    dw       = (VW+1)'(w_j) - (VW+1)'(prev_j);
    dmag     = dw[VW] ? VW'(-dw) : VW'(dw);
    sq       = (prod > SQ_MAX) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
    dsum_add = {1'b0, dsum_q} + {1'b0, sq};
    share_c  = (share_q > ecd_pkg::SHARE_ONE) ? ecd_pkg::SHARE_ONE : share_q;
    if (samples_q == 9'd0)              n_c = NW'(1);
    else if (32'(samples_q) > MS)       n_c = NW'(MS);
    else                                n_c = NW'(samples_q);
    if (features_q == 5'd0)             f_c = FW'(1);
    else if (32'(features_q) > MF)      f_c = FW'(MF);
    else                                f_c = FW'(features_q);
  end

  // Memory strobes
  always_comb begin
    smp_we  = in_fire && (in_i.action == ecd_pkg::ACT_LOAD_X) &&
              (32'(in_i.sample_index) < MS) && (32'(in_i.feature_index) < MF);
    tgt_we  = in_fire && (in_i.action == ecd_pkg::ACT_LOAD_Y) &&
              (32'(in_i.sample_index) < MS);
    smp_re  = (state_q == S_CM_RD) || (state_q == S_XC_RD);
    tgt_re  = (state_q == S_TS_RD) || (state_q == S_YC_RD);
    xc_we   = state_q == S_XC_WR;
    xc_re   = (state_q == S_RH_RD) || (state_q == S_U_RD);
    yc_we   = state_q == S_YC_WR;
    yfs_re  = state_q == S_RH_RD;
    fs_we   = (state_q == S_YC_WR) || (state_q == S_U_WR);
    fs_re   = (state_q == S_RH_RD) || (state_q == S_U_RD);
    fs_wdata = (state_q == S_U_WR) ? fs_new : '0;
  end

  always_ff @(posedge clk_i) begin
    if (smp_we) smp_mem[ld_addr] <= ld_val;
    if (smp_re) smp_rd_q <= smp_mem[x_addr];
  end

  always_ff @(posedge clk_i) begin
    if (xc_we) xc_mem[x_addr] <= c_val;
    if (xc_re) xc_rd_q <= xc_mem[x_addr];
  end

  always_ff @(posedge clk_i) begin
    if (tgt_we) tgt_mem[SIW'(in_i.sample_index)] <= ld_val;
    if (tgt_re) tgt_rd_q <= tgt_mem[i_idx];
  end

  always_ff @(posedge clk_i) begin
    if (yc_we)  yc_mem[i_idx] <= yc_val;
    if (yfs_re) yc_rd_q <= yc_mem[i_idx];
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) fs_mem[i_idx] <= fs_wdata;
    if (fs_re) fs_rd_q <= fs_mem[i_idx];
  end

  // Multiplier operand select
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    mul_en  = 1'b1;
    unique case (state_q)
      S_P1: begin
        mul_a = MW'(alpha_q);
        mul_b = MW'(share_c);
      end
      S_P2: begin
        mul_a = MW'(alpha_q);
        mul_b = MW'(ecd_pkg::SHARE_ONE - share_c);
      end
      S_P3: begin
        mul_a = MW'(l1_q);
        mul_b = MW'(n_q);
      end
      S_P4: begin
        mul_a = MW'(tol_q);
        mul_b = MW'(tol_q);
      end
      S_XC_WR: begin
        mul_a = MW'(mag_v(c_val));
        mul_b = MW'(mag_v(c_val));
      end
      S_RH_M1: begin
        mul_a   = MW'(mag_v(xc_rd_q));
        mul_b   = MW'(mag_v(w_j));
        mul_neg = xc_rd_q[VW-1] ^ w_j[VW-1];
      end
      S_RH_M2: begin
        mul_a   = MW'(mag_v(xc_rd_q));
        mul_b   = MW'(mag_v(r_val));
        mul_neg = xc_rd_q[VW-1] ^ r_val[VW-1];
      end
      S_U_M1: begin
        mul_a   = MW'(mag_v(xc_rd_q));
        mul_b   = MW'(mag_v(wnew_q));
        mul_neg = xc_rd_q[VW-1] ^ wnew_q[VW-1];
      end
      S_U_M2: begin
        mul_a   = MW'(mag_v(xc_rd_q));
        mul_b   = MW'(mag_v(w_j));
        mul_neg = xc_rd_q[VW-1] ^ w_j[VW-1];
      end
      S_DS_MUL: begin
        mul_a = MW'(dmag);
        mul_b = MW'(dmag);
      end
      S_IC_MUL: begin
        mul_a   = MW'(mag_v(mean_j));
        mul_b   = MW'(mag_v(w_j));
        mul_neg = mean_j[VW-1] ^ w_j[VW-1];
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Divider operand select
  always_comb begin
    div_start = (state_q == S_TM_DIV) || (state_q == S_CM_DIV) ||
                ((state_q == S_W_CHK) && (denom > 0));
    div_dvd   = (state_q == S_W_CHK) ? (num_mag << 16) : acc_mag;
    div_dvs   = (state_q == S_W_CHK) ? WW'(denom) : WW'(n_q);
  end

  ecd_mul #(.MW(MW)) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .neg_i  (mul_neg),
    .prod_o (prod),
    .neg_o  (prod_neg)
  );

  ecd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= ecd_pkg::ALPHA_RST;
      share_q    <= ecd_pkg::SHARE_RST;
      limit_q    <= ecd_pkg::ITER_LIM_RST;
      tol_q      <= ecd_pkg::TOL_RST;
      icpt_en_q  <= 1'b1;
      samples_q  <= ecd_pkg::SAMPLES_RST;
      features_q <= ecd_pkg::FEATURES_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        ecd_pkg::REG_ALPHA:    alpha_q    <= pwdata[30:0];
        ecd_pkg::REG_L1_SHARE: share_q    <= pwdata[16:0];
        ecd_pkg::REG_ITER_LIM: limit_q    <= pwdata[15:0];
        ecd_pkg::REG_TOL:      tol_q      <= pwdata[30:0];
        ecd_pkg::REG_ICPT_EN:  icpt_en_q  <= pwdata[0];
        ecd_pkg::REG_SAMPLES:  samples_q  <= pwdata[8:0];
        ecd_pkg::REG_FEATURES: features_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[4:2])
      ecd_pkg::REG_ALPHA:    prdata = 32'(alpha_q);
      ecd_pkg::REG_L1_SHARE: prdata = 32'(share_q);
      ecd_pkg::REG_ITER_LIM: prdata = 32'(limit_q);
      ecd_pkg::REG_TOL:      prdata = 32'(tol_q);
      ecd_pkg::REG_ICPT_EN:  prdata = 32'(icpt_en_q);
      ecd_pkg::REG_SAMPLES:  prdata = 32'(samples_q);
      ecd_pkg::REG_FEATURES: prdata = 32'(features_q);
      default:               prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= NW'(1);
      f_q     <= FW'(1);
      it_q    <= '0;
      conv_q  <= 1'b0;
      tm_q    <= '0;
      for (int k = 0; k < MF; k++) begin
        weights_q[k] <= '0;
        prev_q[k]    <= '0;
      end
    end else begin
      if (out_fire) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && (in_i.action == ecd_pkg::ACT_FIT)) begin
            n_q    <= n_c;
            f_q    <= f_c;
            conv_q <= 1'b0;
            for (int k = 0; k < MF; k++) weights_q[k] <= '0;
            state_q <= S_P1;
          end
        end
        S_P1: state_q <= S_P2;
        S_P2: begin
          l1_q    <= 32'(prod >> 16);
          state_q <= S_P3;
        end
        S_P3: begin
          l2_q    <= 32'(prod >> 16);
          state_q <= S_P4;
        end
        S_P4: begin
          thr_q   <= sat_wide($signed({1'b0, 65'(prod)}));
          state_q <= S_P5;
        end
        S_P5: begin
          tol2_q  <= prod[63:0];
          acc_q   <= '0;
          i_q     <= '0;
          state_q <= S_TS_RD;
        end
        // Sum the targets
        S_TS_RD: state_q <= S_TS_ACC;
        S_TS_ACC: begin
          acc_q <= acc_q + CW'(tgt_rd_q);
          i_q   <= NW'(i_q + 1'b1);
          state_q <= last_i ? S_TM_DIV : S_TS_RD;
        end
        S_TM_DIV: state_q <= S_TM_WAIT;
        S_TM_WAIT: begin
          if (div_done) begin
            tm_q    <= mean_res;
            i_q     <= '0;
            state_q <= S_YC_RD;
          end
        end
        // Center the targets, clear the fit sums
        S_YC_RD: state_q <= S_YC_WR;
        S_YC_WR: begin
          i_q <= NW'(i_q + 1'b1);
          if (last_i) begin
            i_q     <= '0;
            j_q     <= '0;
            acc_q   <= '0;
            state_q <= S_CM_RD;
          end else begin
            state_q <= S_YC_RD;
          end
        end
        // Column mean
        S_CM_RD: state_q <= S_CM_ACC;
        S_CM_ACC: begin
          acc_q <= acc_q + CW'(smp_rd_q);
          i_q   <= NW'(i_q + 1'b1);
          state_q <= last_i ? S_CM_DIV : S_CM_RD;
        end
        S_CM_DIV: state_q <= S_CM_WAIT;
        S_CM_WAIT: begin
          if (div_done) begin
            mean_q[j_idx] <= mean_res;
            i_q     <= '0;
            acc_q   <= '0;
            state_q <= S_XC_RD;
          end
        end
        // Center the column and sum its squares
        S_XC_RD: state_q <= S_XC_WR;
        S_XC_WR: state_q <= S_XC_ACC;
        S_XC_ACC: begin
          acc_q <= acc_sum;
          i_q   <= NW'(i_q + 1'b1);
          if (last_i) begin
            css_q[j_idx] <= sat_wide(66'(acc_sum));
            i_q   <= '0;
            acc_q <= '0;
            j_q   <= FW'(j_q + 1'b1);
            if (last_j) begin
              it_q    <= '0;
              state_q <= S_IT_CHK;
            end else begin
              state_q <= S_CM_RD;
            end
          end else begin
            state_q <= S_XC_RD;
          end
        end
        // Start a sweep, or go to the intercept once the iteration limit is reached
        S_IT_CHK: begin
          if (it_q < limit_q) begin
            for (int k = 0; k < MF; k++) prev_q[k] <= weights_q[k];
            j_q     <= '0;
            i_q     <= '0;
            acc_q   <= '0;
            dsum_q  <= '0;
            state_q <= S_RH_RD;
          end else begin
            state_q <= S_IC;
          end
        end
        // Correlation of the column with the partial residual
        S_RH_RD: state_q <= S_RH_M1;
        S_RH_M1: state_q <= S_RH_M2;
        S_RH_M2: state_q <= S_RH_ACC;
        S_RH_ACC: begin
          acc_q <= acc_sum;
          i_q   <= NW'(i_q + 1'b1);
          if (last_i) begin
            rho_q   <= sat_wide(66'(acc_sum));
            state_q <= S_W_CHK;
          end else begin
            state_q <= S_RH_RD;
          end
        end
        // Soft threshold and divide; keep the weight when the divisor is not positive
        S_W_CHK: begin
          num_neg_q <= num[WW];
          if (denom > 0) begin
            state_q <= S_W_WAIT;
          end else begin
            i_q   <= '0;
            acc_q <= '0;
            j_q   <= last_j ? '0 : FW'(j_q + 1'b1);
            state_q <= last_j ? S_DS_MUL : S_RH_RD;
          end
        end
        S_W_WAIT: begin
          if (div_done) begin
            wnew_q  <= w_res;
            i_q     <= '0;
            state_q <= S_U_RD;
          end
        end
        // Move the fit sums to the new weight
        S_U_RD: state_q <= S_U_M1;
        S_U_M1: state_q <= S_U_M2;
        S_U_M2: begin
          tmp_q   <= q16_p;
          state_q <= S_U_WR;
        end
        S_U_WR: begin
          i_q <= NW'(i_q + 1'b1);
          if (last_i) begin
            weights_q[j_idx] <= wnew_q;
            i_q   <= '0;
            acc_q <= '0;
            j_q   <= last_j ? '0 : FW'(j_q + 1'b1);
            state_q <= last_j ? S_DS_MUL : S_RH_RD;
          end else begin
            state_q <= S_U_RD;
          end
        end
        // Squared weight change of the sweep, then the convergence test
        S_DS_MUL: state_q <= S_DS_ACC;
        S_DS_ACC: begin
          dsum_q <= dsum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum_add[63:0];
          j_q    <= FW'(j_q + 1'b1);
          state_q <= last_j ? S_CONV : S_DS_MUL;
        end
        S_CONV: begin
          if (dsum_q < tol2_q) begin
            conv_q  <= 1'b1;
            state_q <= S_IC;
          end else begin
            it_q    <= it_q + 1'b1;
            state_q <= S_IT_CHK;
          end
        end
        // Intercept from the means, or zero when the intercept is off
        S_IC: begin
          j_q   <= '0;
          acc_q <= '0;
          if (icpt_en_q) begin
            state_q <= S_IC_MUL;
          end else begin
            icpt_q  <= '0;
            state_q <= S_EMIT;
          end
        end
        S_IC_MUL: state_q <= S_IC_ACC;
        S_IC_ACC: begin
          acc_q <= acc_sum;
          j_q   <= FW'(j_q + 1'b1);
          if (last_j) begin
            icpt_q  <= sat_val(66'(tm_q) - 66'(acc_sum));
            j_q     <= '0;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_IC_MUL;
          end
        end
        // Hand out the weights, then the intercept
        S_EMIT: begin
          if (!ov_q || out_o.ready) begin
            ov_q    <= 1'b1;
            oconv_q <= conv_q;
            if (j_q == f_q) begin
              okind_q <= ecd_pkg::KIND_INTERCEPT;
              oidx_q  <= '0;
              ocoef_q <= sat32(66'(icpt_q));
              olast_q <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              okind_q <= ecd_pkg::KIND_WEIGHT;
              oidx_q  <= 4'(j_q);
              ocoef_q <= sat32(66'(w_j));
              olast_q <= 1'b0;
              j_q     <= FW'(j_q + 1'b1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready         = state_q == S_IDLE;
  assign out_o.valid        = ov_q;
  assign out_o.kind         = okind_q;
  assign out_o.weight_index = oidx_q;
  assign out_o.coefficient  = ocoef_q;
  assign out_o.converged    = oconv_q;
  assign out_o.last         = olast_q;

endmodule
